@@ hdl/brl_pkg.sv @@
// ----------------------------------------------------------------------------
// brl_pkg
// Shared constants and types for the line rasterizer: screen geometry,
// coordinate widths, command codes, register indexes and the point beat.
// ----------------------------------------------------------------------------
package brl_pkg;

    // Screen geometry and coordinate width
    localparam int SCREEN_WIDTH  = 240;
    localparam int SCREEN_HEIGHT = 80;
    localparam int COORD_BITS    = 12;

    localparam int HALF_W      = SCREEN_WIDTH / 2;
    localparam int HALF_H      = SCREEN_HEIGHT / 2;
    localparam int SCREEN_AREA = SCREEN_WIDTH * SCREEN_HEIGHT;

    // Derived widths
    localparam int CW     = COORD_BITS;       // coordinate
    localparam int DW     = COORD_BITS + 1;   // twice a delta
    localparam int EW     = COORD_BITS + 3;   // error term
    localparam int ADDR_W = 15;               // pixel address field
    localparam int PIX_W  = 8;                // character code
    localparam int AW     = 32;               // address arithmetic

    // Command codes
    localparam logic [1:0] FUNC_START = 2'd0;
    localparam logic [1:0] FUNC_STEP  = 2'd1;
    localparam logic [1:0] FUNC_PLOT  = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_PIXEL_VALUE = 2'd0;
    localparam logic [1:0] CFG_X_OFFSET    = 2'd1;
    localparam logic [1:0] CFG_Y_OFFSET    = 2'd2;

    localparam logic [PIX_W-1:0] PIXEL_RESET = 8'd219;

    // One screen point handed from the line generator to the address mapper
    typedef struct packed {
        logic                 made;
        logic                 last;
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
    } t_point;

endpackage

@@ hdl/brl_point_gen.sv @@
// ----------------------------------------------------------------------------
// brl_point_gen
// Line state and point register. Decodes one command per beat, sets up or
// advances the Bresenham line and registers the point it yields.
// ----------------------------------------------------------------------------
module brl_point_gen (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_load,
    input  logic                          i_adv,
    input  logic [1:0]                    i_func,
    input  logic signed [brl_pkg::CW-1:0] i_x_start,
    input  logic signed [brl_pkg::CW-1:0] i_y_start,
    input  logic signed [brl_pkg::CW-1:0] i_x_end,
    input  logic signed [brl_pkg::CW-1:0] i_y_end,
    output logic                          o_pt_valid,
    output brl_pkg::t_point               o_pt
);

    localparam int CW = brl_pkg::CW;
    localparam int DW = brl_pkg::DW;
    localparam int EW = brl_pkg::EW;

    // Line state
    logic                 r_active;
    logic                 r_steep;
    logic                 r_neg;
    logic signed [CW-1:0] r_major_pos;
    logic signed [CW-1:0] r_minor_pos;
    logic signed [CW-1:0] r_major_end;
    logic signed [EW-1:0] r_err;
    logic [DW-1:0]        r_twice_maj;
    logic [DW-1:0]        r_twice_min;

    logic                 n_active;
    logic                 n_steep;
    logic                 n_neg;
    logic signed [CW-1:0] n_major_pos;
    logic signed [CW-1:0] n_minor_pos;
    logic signed [CW-1:0] n_major_end;
    logic signed [EW-1:0] n_err;
    logic [DW-1:0]        n_twice_maj;
    logic [DW-1:0]        n_twice_min;

    logic                 r_pt_valid;
    brl_pkg::t_point      r_pt;
    brl_pkg::t_point      n_pt;

    // Line setup from the endpoints
    logic signed [CW:0]   dx, dy, dx_neg, dy_neg;
    logic [CW-1:0]        adx, ady;
    logic                 f_steep, f_swap;
    logic signed [CW-1:0] a0, a1, b0, b1;
    logic signed [CW-1:0] maj0, maj1, min0, min1;
    logic signed [CW:0]   dmaj, dmin, dmin_neg;
    logic [CW-1:0]        admin;
    logic signed [EW-1:0] f_err;

    // Working line values (fresh on start, stored on step)
    logic                 c_steep, c_neg, c_last, c_dec;
    logic signed [CW-1:0] c_major_pos, c_minor_pos, c_major_end;
    logic signed [EW-1:0] c_err;
    logic [DW-1:0]        c_twice_maj, c_twice_min;
    logic signed [CW-1:0] adv_minor;
    logic signed [EW-1:0] adv_err;
    logic                 is_start;

    always_comb begin
        dx     = {i_x_end[CW-1], i_x_end} - {i_x_start[CW-1], i_x_start};
        dy     = {i_y_end[CW-1], i_y_end} - {i_y_start[CW-1], i_y_start};
        dx_neg = -dx;
        dy_neg = -dy;
        adx    = dx[CW] ? dx_neg[CW-1:0] : dx[CW-1:0];
        ady    = dy[CW] ? dy_neg[CW-1:0] : dy[CW-1:0];
        // ties go to the steep case
        f_steep = !(ady < adx);
        a0 = f_steep ? i_y_start : i_x_start;
        b0 = f_steep ? i_x_start : i_y_start;
        a1 = f_steep ? i_y_end   : i_x_end;
        b1 = f_steep ? i_x_end   : i_y_end;
        f_swap = a0 > a1;
        maj0 = f_swap ? a1 : a0;
        maj1 = f_swap ? a0 : a1;
        min0 = f_swap ? b1 : b0;
        min1 = f_swap ? b0 : b1;
        dmaj     = {maj1[CW-1], maj1} - {maj0[CW-1], maj0};
        dmin     = {min1[CW-1], min1} - {min0[CW-1], min0};
        dmin_neg = -dmin;
        admin    = dmin[CW] ? dmin_neg[CW-1:0] : dmin[CW-1:0];
        f_err    = $signed({2'b00, admin, 1'b0}) - $signed({3'b000, dmaj[CW-1:0]});
    end

    always_comb begin
        is_start    = (i_func == brl_pkg::FUNC_START);
        c_steep     = is_start ? f_steep          : r_steep;
        c_neg       = is_start ? dmin[CW]         : r_neg;
        c_major_pos = is_start ? maj0             : r_major_pos;
        c_minor_pos = is_start ? min0             : r_minor_pos;
        c_major_end = is_start ? maj1             : r_major_end;
        c_err       = is_start ? f_err            : r_err;
        c_twice_maj = is_start ? {dmaj[CW-1:0], 1'b0} : r_twice_maj;
        c_twice_min = is_start ? {admin, 1'b0}    : r_twice_min;

        c_last    = c_major_pos >= c_major_end;
        c_dec     = c_err > 0;
        adv_minor = c_dec ? (c_neg ? c_minor_pos - CW'(1) : c_minor_pos + CW'(1))
                          : c_minor_pos;
        adv_err   = c_err + $signed({2'b00, c_twice_min})
                  - (c_dec ? $signed({2'b00, c_twice_maj}) : $signed(EW'(0)));
    end

    // Command decode: next state and the point this beat yields
    always_comb begin
        n_active    = r_active;
        n_steep     = r_steep;
        n_neg       = r_neg;
        n_major_pos = r_major_pos;
        n_minor_pos = r_minor_pos;
        n_major_end = r_major_end;
        n_err       = r_err;
        n_twice_maj = r_twice_maj;
        n_twice_min = r_twice_min;
        n_pt        = '0;

        case (i_func)
            brl_pkg::FUNC_START, brl_pkg::FUNC_STEP: begin
                if (is_start || r_active) begin
                    n_pt.made   = 1'b1;
                    n_pt.last   = c_last;
                    n_pt.x      = c_steep ? c_minor_pos : c_major_pos;
                    n_pt.y      = c_steep ? c_major_pos : c_minor_pos;
                    n_active    = !c_last;
                    n_steep     = c_steep;
                    n_neg       = c_neg;
                    n_major_end = c_major_end;
                    n_twice_maj = c_twice_maj;
                    n_twice_min = c_twice_min;
                    n_major_pos = c_last ? c_major_pos : c_major_pos + CW'(1);
                    n_minor_pos = c_last ? c_minor_pos : adv_minor;
                    n_err       = c_last ? c_err       : adv_err;
                end
            end
            brl_pkg::FUNC_PLOT: begin
                n_pt.made = 1'b1;
                n_pt.last = 1'b1;
                n_pt.x    = i_x_start;
                n_pt.y    = i_y_start;
            end
            default: begin
                n_pt = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active   <= 1'b0;
            r_pt_valid <= 1'b0;
        end else begin
            if (i_load) begin
                r_active   <= n_active;
                r_pt_valid <= 1'b1;
            end else if (i_adv) begin
                r_pt_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_steep     <= n_steep;
            r_neg       <= n_neg;
            r_major_pos <= n_major_pos;
            r_minor_pos <= n_minor_pos;
            r_major_end <= n_major_end;
            r_err       <= n_err;
            r_twice_maj <= n_twice_maj;
            r_twice_min <= n_twice_min;
            r_pt        <= n_pt;
        end
    end

    assign o_pt_valid = r_pt_valid;
    assign o_pt       = r_pt;

endmodule

@@ hdl/brl_addr_map.sv @@
// ----------------------------------------------------------------------------
// brl_addr_map
// Maps a screen point to a linear buffer address, checks it against the
// buffer size and holds the result beat in the output register.
// ----------------------------------------------------------------------------
module brl_addr_map (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_adv,
    input  logic                             i_pt_valid,
    input  brl_pkg::t_point                  i_pt,
    input  logic [brl_pkg::PIX_W-1:0]        i_pixel_value,
    input  logic signed [brl_pkg::CW-1:0]    i_x_offset,
    input  logic signed [brl_pkg::CW-1:0]    i_y_offset,
    output logic                             o_valid,
    output logic                             o_point_made,
    output logic                             o_write_enable,
    output logic [brl_pkg::ADDR_W-1:0]       o_pixel_address,
    output logic [brl_pkg::PIX_W-1:0]        o_pixel_value_res,
    output logic                             o_last_point
);

    localparam int CW = brl_pkg::CW;
    localparam int AW = brl_pkg::AW;

    logic signed [CW:0]   sx, sy;
    logic signed [AW-1:0] xs, row, addr;
    logic                 in_screen;

    logic                        r_valid;
    logic                        r_made, r_we, r_last;
    logic [brl_pkg::ADDR_W-1:0]  r_addr;
    logic [brl_pkg::PIX_W-1:0]   r_pix;

    always_comb begin
        sx     = {i_pt.x[CW-1], i_pt.x} + {i_x_offset[CW-1], i_x_offset};
        sy     = {i_pt.y[CW-1], i_pt.y} + {i_y_offset[CW-1], i_y_offset};
        xs     = AW'(sx) <<< 1;
        // y axis points up on screen
        row    = AW'(brl_pkg::HALF_H) - AW'(sy);
        addr   = row * AW'(brl_pkg::SCREEN_WIDTH) + xs + AW'(brl_pkg::HALF_W);
        in_screen = i_pt.made && (addr >= 0) && (addr < AW'(brl_pkg::SCREEN_AREA));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_pt_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_made <= i_pt.made;
            r_we   <= in_screen;
            r_addr <= in_screen ? addr[brl_pkg::ADDR_W-1:0] : '0;
            r_pix  <= i_pt.made ? i_pixel_value : '0;
            r_last <= i_pt.last;
        end
    end

    assign o_valid           = r_valid;
    assign o_point_made      = r_made;
    assign o_write_enable    = r_we;
    assign o_pixel_address   = r_addr;
    assign o_pixel_value_res = r_pix;
    assign o_last_point      = r_last;

endmodule

@@ hdl/bresenham_line_rasterizer_top.sv @@
// ----------------------------------------------------------------------------
// bresenham_line_rasterizer_top
// A command beat moves from the point register into the result register.
// Throughput: one command beat per cycle while the result side does not stall; the
//   line state advances combinationally in the point generator; steps never wait.
// Reset (synchronous, active low): no line in progress, both pipeline stages
//   empty, pixel_value = 219, x_offset = y_offset = 0.
// ----------------------------------------------------------------------------
module bresenham_line_rasterizer_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,

    // Command channel
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [1:0]                       i_func,
    input  logic signed [brl_pkg::CW-1:0]    i_x_start,
    input  logic signed [brl_pkg::CW-1:0]    i_y_start,
    input  logic signed [brl_pkg::CW-1:0]    i_x_end,
    input  logic signed [brl_pkg::CW-1:0]    i_y_end,

    // Result channel
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic                             o_point_made,
    output logic                             o_write_enable,
    output logic [brl_pkg::ADDR_W-1:0]       o_pixel_address,
    output logic [brl_pkg::PIX_W-1:0]        o_pixel_value_res,
    output logic                             o_last_point,

    // Register write port
    input  logic                             i_cfg_we,
    input  logic [1:0]                       i_cfg_index,
    input  logic [brl_pkg::CW-1:0]           i_cfg_data
);

    // Configuration registers
    logic [brl_pkg::PIX_W-1:0]     r_pixel_value;
    logic signed [brl_pkg::CW-1:0] r_x_offset;
    logic signed [brl_pkg::CW-1:0] r_y_offset;

    // Pipeline control.
    // Output stage moves when empty or when its beat is taken.
    // Point stage takes a new command when empty or when it drains forward,
    // so the channel stalls only when both stages are full and the result waits.
    logic            adv_out;
    logic            pt_valid;
    logic            in_accept;
    brl_pkg::t_point pt;

    assign adv_out    = !o_out_valid || !i_out_stall;
    assign o_in_stall = pt_valid && !adv_out;
    assign in_accept  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pixel_value <= brl_pkg::PIXEL_RESET;
            r_x_offset    <= '0;
            r_y_offset    <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                brl_pkg::CFG_PIXEL_VALUE: r_pixel_value <= i_cfg_data[brl_pkg::PIX_W-1:0];
                brl_pkg::CFG_X_OFFSET:    r_x_offset    <= i_cfg_data;
                brl_pkg::CFG_Y_OFFSET:    r_y_offset    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Stage 1: command decode, line setup/advance, point register
    brl_point_gen u_point_gen (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (in_accept),
        .i_adv      (adv_out),
        .i_func     (i_func),
        .i_x_start  (i_x_start),
        .i_y_start  (i_y_start),
        .i_x_end    (i_x_end),
        .i_y_end    (i_y_end),
        .o_pt_valid (pt_valid),
        .o_pt       (pt)
    );

    // Stage 2: screen mapping, bounds check, result register
    brl_addr_map u_addr_map (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_adv             (adv_out),
        .i_pt_valid        (pt_valid),
        .i_pt              (pt),
        .i_pixel_value     (r_pixel_value),
        .i_x_offset        (r_x_offset),
        .i_y_offset        (r_y_offset),
        .o_valid           (o_out_valid),
        .o_point_made      (o_point_made),
        .o_write_enable    (o_write_enable),
        .o_pixel_address   (o_pixel_address),
        .o_pixel_value_res (o_pixel_value_res),
        .o_last_point      (o_last_point)
    );

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------

    // A beat without a point carries nothing else
    a_empty_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_point_made |->
            !o_write_enable && !o_last_point && o_pixel_value_res == '0)
        else $error("empty beat carries payload");

    // Address is zero unless written, and in range when written
    a_addr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_write_enable ?
            (32'(o_pixel_address) < 32'(brl_pkg::SCREEN_AREA)) : (o_pixel_address == '0)))
        else $error("pixel address out of range");

    // The point stage cannot be overwritten while it is blocked
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pt_valid && o_out_valid && i_out_stall |-> !in_accept)
        else $error("point stage overrun");

    // A stalled command stage keeps its point
    a_pt_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pt_valid && !adv_out && !in_accept |=> pt_valid && $stable(pt))
        else $error("held point changed");

endmodule

@@ tb/bresenham_line_rasterizer_top_tb.sv @@
// ----------------------------------------------------------------------------
// bresenham_line_rasterizer_top_tb
// Self-checking bench for the character-screen line rasterizer. A directed
// table covers screen corners, clipping, idle steps, the spare command code
// and line setup corner cases. Random line bursts with interleaved plots and
// noise follow under several register settings and back-pressure mixes.
// Every result beat is checked against hand-checked values or an in-bench model.
// ----------------------------------------------------------------------------
module bresenham_line_rasterizer_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW     = brl_pkg::CW;
    localparam int ADDR_W = brl_pkg::ADDR_W;
    localparam int PIX_W  = brl_pkg::PIX_W;

    // Unused command code; the block answers it with an empty beat
    localparam logic [1:0] FUNC_SPARE = 2'd3;

    // One result beat as the block presents it
    typedef struct packed {
        logic              made;
        logic              wr_en;
        logic [ADDR_W-1:0] addr;
        logic [PIX_W-1:0]  pix;
        logic              last;
    } t_pixel_beat;

    localparam t_pixel_beat NO_POINT = '0;

    // Directed stimulus row; want is used only when typed is set
    typedef struct packed {
        logic [1:0]           func;
        logic signed [CW-1:0] xa;
        logic signed [CW-1:0] ya;
        logic signed [CW-1:0] xb;
        logic signed [CW-1:0] yb;
        logic                 typed;
        t_pixel_beat          want;
    } t_cmd_row;

    typedef struct packed {
        logic [PIX_W-1:0]     pix;
        logic signed [CW-1:0] x_off;
        logic signed [CW-1:0] y_off;
    } t_reg_set;

    localparam int N_DIRECTED = 28;
    localparam int N_SEGMENTS = 6;
    localparam int SEG_ITEMS  = 205;

    // Hand-checked rows (reset registers: char 219, no offsets):
    //   origin -> 40*240 + 120 = 9720; far corner -> 79*240 + 238 = 19198;
    //   near corner -> 0; one past the end (19200) is clipped.
    t_cmd_row directed_rows [N_DIRECTED] = '{
        '{brl_pkg::FUNC_PLOT,  12'sd0,     12'sd0,     12'sd0,    12'sd0,    1'b1,
          '{1'b1, 1'b1, 15'd9720, 8'd219, 1'b1}},
        '{brl_pkg::FUNC_STEP,  12'sd0,     12'sd0,     12'sd0,    12'sd0,    1'b1, NO_POINT},
        '{FUNC_SPARE, -12'sd1,    -12'sd1,    -12'sd1,   -12'sd1,   1'b1, NO_POINT},
        '{brl_pkg::FUNC_PLOT,  12'sd2047,  12'sd2047,  12'sd0,    12'sd0,    1'b1,
          '{1'b1, 1'b0, 15'd0, 8'd219, 1'b1}},
        '{brl_pkg::FUNC_PLOT,  -12'sd2048, -12'sd2048, 12'sd0,    12'sd0,    1'b1,
          '{1'b1, 1'b0, 15'd0, 8'd219, 1'b1}},
        '{brl_pkg::FUNC_START, 12'sd5,     12'sd5,     12'sd5,    12'sd5,    1'b1,
          '{1'b1, 1'b1, 15'd8530, 8'd219, 1'b1}},
        '{brl_pkg::FUNC_STEP,  12'sd0,     12'sd0,     12'sd0,    12'sd0,    1'b1, NO_POINT},
        '{brl_pkg::FUNC_PLOT,  12'sd59,    -12'sd39,   12'sd0,    12'sd0,    1'b1,
          '{1'b1, 1'b1, 15'd19198, 8'd219, 1'b1}},
        '{brl_pkg::FUNC_PLOT,  -12'sd60,   12'sd40,    12'sd0,    12'sd0,    1'b1,
          '{1'b1, 1'b1, 15'd0, 8'd219, 1'b1}},
        '{brl_pkg::FUNC_PLOT,  12'sd60,    -12'sd39,   12'sd0,    12'sd0,    1'b1,
          '{1'b1, 1'b0, 15'd0, 8'd219, 1'b1}},
        // shallow line, with a plot in the middle that must not disturb it
        '{brl_pkg::FUNC_START, 12'sd0,     12'sd0,     12'sd6,    12'sd2,    1'b0, NO_POINT},
        '{brl_pkg::FUNC_STEP,  12'sd0,     12'sd0,     12'sd0,    12'sd0,    1'b0, NO_POINT},
        '{brl_pkg::FUNC_PLOT,  -12'sd3,    12'sd1,     12'sd0,    12'sd0,    1'b0, NO_POINT},
        '{brl_pkg::FUNC_STEP,  12'sd0,     12'sd0,     12'sd0,    12'sd0,    1'b0, NO_POINT},
        '{brl_pkg::FUNC_STEP,  12'sd0,     12'sd0,     12'sd0,    12'sd0,    1'b0, NO_POINT},
        '{brl_pkg::FUNC_STEP,  12'sd0,     12'sd0,     12'sd0,    12'sd0,    1'b0, NO_POINT},
        '{brl_pkg::FUNC_STEP,  12'sd0,     12'sd0,     12'sd0,    12'sd0,    1'b0, NO_POINT},
        '{brl_pkg::FUNC_STEP,  12'sd0,     12'sd0,     12'sd0,    12'sd0,    1'b0, NO_POINT},
        '{brl_pkg::FUNC_STEP,  12'sd0,     12'sd0,     12'sd0,    12'sd0,    1'b0, NO_POINT},
        // steep line drawn backwards, then dropped by a new start
        '{brl_pkg::FUNC_START, 12'sd3,     12'sd4,     -12'sd2,   -12'sd7,   1'b0, NO_POINT},
        '{brl_pkg::FUNC_STEP,  12'sd0,     12'sd0,     12'sd0,    12'sd0,    1'b0, NO_POINT},
        '{brl_pkg::FUNC_START, 12'sd10,    -12'sd1,    -12'sd10,  12'sd3,    1'b0, NO_POINT},
        '{brl_pkg::FUNC_STEP,  12'sd0,     12'sd0,     12'sd0,    12'sd0,    1'b0, NO_POINT},
        // equal deltas take the steep branch
        '{brl_pkg::FUNC_START, 12'sd0,     12'sd0,     12'sd3,    -12'sd3,   1'b0, NO_POINT},
        '{brl_pkg::FUNC_START, -12'sd2048, -12'sd2048, 12'sd2047, 12'sd2047, 1'b0, NO_POINT},
        '{brl_pkg::FUNC_STEP,  12'sd0,     12'sd0,     12'sd0,    12'sd0,    1'b0, NO_POINT},
        '{brl_pkg::FUNC_START, 12'sd2047,  -12'sd2048, -12'sd2048, 12'sd2047, 1'b0, NO_POINT},
        '{brl_pkg::FUNC_STEP,  12'sd0,     12'sd0,     12'sd0,    12'sd0,    1'b0, NO_POINT}
    };

    // Register settings per random segment, extremes included
    t_reg_set reg_sets [N_SEGMENTS] = '{
        '{8'd0,   12'sd0,     12'sd0},
        '{8'd255, -12'sd2048, 12'sd2047},
        '{8'h5a,  12'sd2047,  -12'sd2048},
        '{8'd219, 12'sd10,    -12'sd5},
        '{8'd1,   -12'sd30,   12'sd17},
        '{8'd128, 12'sd0,     12'sd0}
    };

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic [1:0]           i_func;
    logic signed [CW-1:0] i_x_start;
    logic signed [CW-1:0] i_y_start;
    logic signed [CW-1:0] i_x_end;
    logic signed [CW-1:0] i_y_end;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic                 o_point_made;
    logic                 o_write_enable;
    logic [ADDR_W-1:0]    o_pixel_address;
    logic [PIX_W-1:0]     o_pixel_value_res;
    logic                 o_last_point;
    logic                 i_cfg_we;
    logic [1:0]           i_cfg_index;
    logic [CW-1:0]        i_cfg_data;

    bresenham_line_rasterizer_top dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_func            (i_func),
        .i_x_start         (i_x_start),
        .i_y_start         (i_y_start),
        .i_x_end           (i_x_end),
        .i_y_end           (i_y_end),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_point_made      (o_point_made),
        .o_write_enable    (o_write_enable),
        .o_pixel_address   (o_pixel_address),
        .o_pixel_value_res (o_pixel_value_res),
        .o_last_point      (o_last_point),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    // ------------------------------------------------------------------
    // Rasterizer model: registers, line state and bookkeeping
    // ------------------------------------------------------------------
    logic [PIX_W-1:0] char_code;
    int               x_shift;
    int               y_shift;
    bit               line_on;
    bit               steep;
    int               maj_pos;
    int               mnr_pos;
    int               maj_stop;
    bit               mnr_down;
    int               err_acc;
    int               maj_twice;
    int               mnr_twice;

    t_pixel_beat      expected_points[$];
    int               errors;
    int               beats_checked;
    int               cmds_sent;
    int               lines_started;
    int               plots_sent;
    int               pts_written;
    int               pts_clipped;

    // Idle odds (percent per cycle) and a long receiver hold-off request
    int               sender_idle_pct;
    int               recv_idle_pct;
    int               hold_left;

    function automatic int mag(input int v);
        return v < 0 ? -v : v;
    endfunction

    // Screen mapping: x doubled for the character aspect, y flipped,
    // origin at the center; only the linear address is bounds-checked.
    function automatic t_pixel_beat map_point(input int x, input int y, input bit last);
        t_pixel_beat r;
        int          xs;
        int          ys;
        int          lin;
        xs = 2 * (x + x_shift);
        ys = -(y + y_shift);
        lin = (ys + brl_pkg::HALF_H) * brl_pkg::SCREEN_WIDTH + xs + brl_pkg::HALF_W;
        r.made = 1'b1;
        r.wr_en = (lin >= 0) && (lin < brl_pkg::SCREEN_AREA);
        r.addr = r.wr_en ? lin[ADDR_W-1:0] : '0;
        r.pix = char_code;
        r.last = last;
        return r;
    endfunction

    // Emit the current line point, then advance the error term
    function automatic t_pixel_beat advance_line();
        t_pixel_beat r;
        bit          last;
        last = maj_pos >= maj_stop;
        r = steep ? map_point(mnr_pos, maj_pos, last) : map_point(maj_pos, mnr_pos, last);
        if (last) begin
            line_on = 1'b0;
        end else begin
            if (err_acc > 0) begin
                mnr_pos += mnr_down ? -1 : 1;
                err_acc -= maj_twice;
            end
            err_acc += mnr_twice;
            maj_pos += 1;
            line_on = 1'b1;
        end
        return r;
    endfunction

    function automatic t_pixel_beat rasterize_cmd(input logic [1:0] f,
                                                  input logic signed [CW-1:0] xa,
                                                  input logic signed [CW-1:0] ya,
                                                  input logic signed [CW-1:0] xb,
                                                  input logic signed [CW-1:0] yb);
        t_pixel_beat r;
        int          x0, y0, x1, y1;
        int          a0, b0, a1, b1, t, dmin;
        r = NO_POINT;
        x0 = xa;
        y0 = ya;
        x1 = xb;
        y1 = yb;
        case (f)
            brl_pkg::FUNC_START: begin
                lines_started++;
                steep = !(mag(y1 - y0) < mag(x1 - x0));
                if (steep) begin
                    a0 = y0; b0 = x0; a1 = y1; b1 = x1;
                end else begin
                    a0 = x0; b0 = y0; a1 = x1; b1 = y1;
                end
                // major axis always runs upward
                if (a0 > a1) begin
                    t = a0; a0 = a1; a1 = t;
                    t = b0; b0 = b1; b1 = t;
                end
                dmin = b1 - b0;
                mnr_down = dmin < 0;
                dmin = mag(dmin);
                maj_pos = a0;
                mnr_pos = b0;
                maj_stop = a1;
                maj_twice = 2 * (a1 - a0);
                mnr_twice = 2 * dmin;
                err_acc = 2 * dmin - (a1 - a0);
                r = advance_line();
            end
            brl_pkg::FUNC_STEP: begin
                if (line_on) begin
                    r = advance_line();
                end
            end
            brl_pkg::FUNC_PLOT: begin
                plots_sent++;
                r = map_point(x0, y0, 1'b1);
            end
            default: begin
                r = NO_POINT;
            end
        endcase
        if (r.made && r.wr_en) pts_written++;
        if (r.made && !r.wr_en) pts_clipped++;
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        errors++;
        $display("ERROR @%0t: %s", $time, msg);
    endtask

    // ------------------------------------------------------------------
    // Clock and watchdog
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #3_000_000;
        $display("bresenham_line_rasterizer_top_tb: FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // Result side: random stall, optional long hold-off, beat checking.
    // Signals are read right after the edge, so they hold their pre-edge
    // values; the stall used for acceptance is the one driven last cycle.
    // ------------------------------------------------------------------
    initial begin : result_side
        t_pixel_beat got;
        t_pixel_beat want;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (o_out_valid === 1'b1 && !i_out_stall) begin
                got = '{o_point_made, o_write_enable, o_pixel_address,
                        o_pixel_value_res, o_last_point};
                beats_checked++;
                if (expected_points.size() == 0) begin
                    report_mismatch("result beat with no command pending");
                end else begin
                    want = expected_points.pop_front();
                    if (got.made !== want.made)
                        report_mismatch($sformatf("beat %0d point_made %b, want %b",
                                                  beats_checked, got.made, want.made));
                    if (got.wr_en !== want.wr_en)
                        report_mismatch($sformatf("beat %0d write_enable %b, want %b",
                                                  beats_checked, got.wr_en, want.wr_en));
                    if (got.addr !== want.addr)
                        report_mismatch($sformatf("beat %0d pixel_address %0d, want %0d",
                                                  beats_checked, got.addr, want.addr));
                    if (got.pix !== want.pix)
                        report_mismatch($sformatf("beat %0d pixel_value %0d, want %0d",
                                                  beats_checked, got.pix, want.pix));
                    if (got.last !== want.last)
                        report_mismatch($sformatf("beat %0d last_point %b, want %b",
                                                  beats_checked, got.last, want.last));
                end
            end
            // hold-off is counted here so the sender keeps pushing meanwhile
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    // ------------------------------------------------------------------
    // Command side helpers
    // ------------------------------------------------------------------
    function automatic logic signed [CW-1:0] rand_any();
        return CW'($urandom);
    endfunction

    // Mostly near the visible area, sometimes anywhere in range
    function automatic logic signed [CW-1:0] rand_coord();
        int v;
        if ($urandom_range(7) == 0) begin
            return CW'($urandom);
        end
        v = $urandom_range(150);
        v = v - 75;
        return v[CW-1:0];
    endfunction

    // Offer one command beat; the model runs at the accepting edge
    task automatic send_cmd(input logic [1:0] f,
                            input logic signed [CW-1:0] xa,
                            input logic signed [CW-1:0] ya,
                            input logic signed [CW-1:0] xb,
                            input logic signed [CW-1:0] yb,
                            input bit typed,
                            input t_pixel_beat want);
        t_pixel_beat p;
        while ($urandom_range(99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_func <= f;
        i_x_start <= xa;
        i_y_start <= ya;
        i_x_end <= xb;
        i_y_end <= yb;
        do @(posedge i_clk); while (o_in_stall);
        p = rasterize_cmd(f, xa, ya, xb, yb);
        expected_points.push_back(typed ? want : p);
        cmds_sent++;
    endtask

    // Stop offering and wait until every pending beat has come back
    task automatic drain();
        i_in_valid <= 1'b0;
        wait (expected_points.size() == 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_regs(input t_reg_set s);
        i_cfg_we <= 1'b1;
        i_cfg_index <= brl_pkg::CFG_PIXEL_VALUE;
        i_cfg_data <= CW'(s.pix);
        @(posedge i_clk);
        char_code = s.pix;
        i_cfg_index <= brl_pkg::CFG_X_OFFSET;
        i_cfg_data <= s.x_off;
        @(posedge i_clk);
        x_shift = $signed(s.x_off);
        i_cfg_index <= brl_pkg::CFG_Y_OFFSET;
        i_cfg_data <= s.y_off;
        @(posedge i_clk);
        y_shift = $signed(s.y_off);
        i_cfg_we <= 1'b0;
    endtask

    // Random traffic: mostly complete line bursts (start plus steps, with
    // stray plots mixed in), some cut short by the next start, plus plots,
    // idle steps and the spare code as noise.
    task automatic run_random(input int quota);
        int                   sent, pick, n, len, ax, ay, bx, by, d;
        logic signed [CW-1:0] xa, ya, xb, yb;
        sent = 0;
        while (sent < quota) begin
            pick = $urandom_range(99);
            if (pick < 70) begin
                xa = rand_coord();
                ya = rand_coord();
                ax = xa;
                ay = ya;
                if ($urandom_range(11) == 0) begin
                    xb = rand_any();
                    yb = rand_any();
                end else begin
                    d = $urandom_range(40);
                    bx = ax + d - 20;
                    d = $urandom_range(40);
                    by = ay + d - 20;
                    xb = bx[CW-1:0];
                    yb = by[CW-1:0];
                end
                bx = xb;
                by = yb;
                len = mag(bx - ax) > mag(by - ay) ? mag(bx - ax) : mag(by - ay);
                n = len > 40 ? 40 : len;
                if ($urandom_range(19) == 0) n = $urandom_range(n);
                else n += $urandom_range(2);
                send_cmd(brl_pkg::FUNC_START, xa, ya, xb, yb, 1'b0, NO_POINT);
                sent++;
                repeat (n) begin
                    if ($urandom_range(9) == 0) begin
                        send_cmd(brl_pkg::FUNC_PLOT, rand_coord(), rand_coord(), rand_any(),
                                 rand_any(), 1'b0, NO_POINT);
                        sent++;
                    end
                    send_cmd(brl_pkg::FUNC_STEP, rand_any(), rand_any(), rand_any(),
                             rand_any(), 1'b0, NO_POINT);
                    sent++;
                end
            end else if (pick < 88) begin
                send_cmd(brl_pkg::FUNC_PLOT, rand_coord(), rand_coord(), rand_any(),
                         rand_any(), 1'b0, NO_POINT);
                sent++;
            end else if (pick < 95) begin
                send_cmd(brl_pkg::FUNC_STEP, rand_any(), rand_any(), rand_any(), rand_any(),
                         1'b0, NO_POINT);
                sent++;
            end else begin
                send_cmd(FUNC_SPARE, rand_any(), rand_any(), rand_any(), rand_any(),
                         1'b0, NO_POINT);
                sent++;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : main_seq
        int n;
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_func <= brl_pkg::FUNC_STEP;
        i_x_start <= '0;
        i_y_start <= '0;
        i_x_end <= '0;
        i_y_end <= '0;
        i_cfg_we <= 1'b0;
        i_cfg_index <= brl_pkg::CFG_PIXEL_VALUE;
        i_cfg_data <= '0;

        // model starts from the documented reset state
        char_code = brl_pkg::PIXEL_RESET;
        x_shift = 0;
        y_shift = 0;
        line_on = 1'b0;
        steep = 1'b0;
        maj_pos = 0;
        mnr_pos = 0;
        maj_stop = 0;
        mnr_down = 1'b0;
        err_acc = 0;
        maj_twice = 0;
        mnr_twice = 0;
        errors = 0;
        beats_checked = 0;
        cmds_sent = 0;
        lines_started = 0;
        plots_sent = 0;
        pts_written = 0;
        pts_clipped = 0;
        hold_left = 0;
        sender_idle_pct = 15;
        recv_idle_pct = 61;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table under reset register values
        for (int i = 0; i < N_DIRECTED; i++) begin
            send_cmd(directed_rows[i].func, directed_rows[i].xa, directed_rows[i].ya,
                     directed_rows[i].xb, directed_rows[i].yb,
                     directed_rows[i].typed, directed_rows[i].want);
        end

        // random segments: slow receiver, then slow sender, then full rate
        for (int seg = 0; seg < N_SEGMENTS; seg++) begin
            drain();
            write_regs(reg_sets[seg]);
            if (seg < 2) begin
                sender_idle_pct = 15;
                recv_idle_pct = 61;
            end else if (seg < 4) begin
                sender_idle_pct = 61;
                recv_idle_pct = 15;
            end else begin
                sender_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (seg == 3) begin
                // long receiver hold-off while commands keep coming
                sender_idle_pct = 0;
                hold_left = 150;
            end
            if (seg == 4) begin
                run_random(SEG_ITEMS / 2);
                drain();
                run_random(SEG_ITEMS - SEG_ITEMS / 2);
            end else begin
                run_random(SEG_ITEMS);
            end
        end

        // wind down: everything back, then spare cycles for strays
        i_in_valid <= 1'b0;
        n = 0;
        while (expected_points.size() != 0 && n < 5000) begin
            @(posedge i_clk);
            n++;
        end
        repeat (8) @(posedge i_clk);
        if (expected_points.size() != 0) begin
            report_mismatch($sformatf("%0d expected beats never arrived",
                                      expected_points.size()));
        end

        $display("Run: %0d commands, %0d lines, %0d single plots, %0d beats checked",
                 cmds_sent, lines_started, plots_sent, beats_checked);
        $display("Points: %0d written, %0d off screen; %0d register settings, %0d errors",
                 pts_written, pts_clipped, N_SEGMENTS + 1, errors);
        if (errors == 0) begin
            $display("bresenham_line_rasterizer_top_tb: PASS");
        end else begin
            $display("bresenham_line_rasterizer_top_tb: FAIL");
        end
        $finish;
    end

endmodule
